FILE: hw/rtl/pbc_pkg.sv
// Shared definitions for the plane/box contact unit.
// Holds default widths, configuration register codes and the stage control word.
// No dependencies.
`default_nettype none

package pbc_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int COORD_FRAC_DEF  = 8;
  localparam int NORMAL_FRAC_DEF = 14;

  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PLANE_DISABLED = 3'd0,
    CFG_TWO_SIDED      = 3'd1,
    CFG_PROJECT        = 3'd2,
    CFG_ORIGIN         = 3'd3,
    CFG_NORMAL         = 3'd4,
    CFG_BOX_LOW        = 3'd5,
    CFG_BOX_HIGH       = 3'd6
  } cfg_reg_t;

  localparam int FLAG_WIDTH    = 3;
  localparam int FLAG_BLOCKING = 0;
  localparam int FLAG_STATIC   = 1;
  localparam int FLAG_IGNORE   = 2;

  typedef struct packed {
    logic valid;
    logic reject;
    logic neg;
  } pbc_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pbc_geom.sv
// Front stages: box overlap and flag rejection, center/extent offsets,
// normal products and their sums (three register stages).
// Depends on pbc_pkg.
`default_nettype none

module pbc_geom #(
  parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC = pbc_pkg::NORMAL_FRAC_DEF,
  localparam int NW  = NORMAL_FRAC + 2,
  localparam int DW  = NORMAL_FRAC + COORD_WIDTH + 7,
  localparam int NEW = NORMAL_FRAC + COORD_WIDTH + 5,
  localparam int E2W = 2 * COORD_WIDTH + 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [6*COORD_WIDTH-1:0]       box,
  input  logic [pbc_pkg::FLAG_WIDTH-1:0] flags,
  input  logic                           plane_disabled,
  input  logic [3*COORD_WIDTH-1:0]       plane_origin,
  input  logic [3*NW-1:0]                plane_normal,
  input  logic [3*COORD_WIDTH-1:0]       plane_box_low,
  input  logic [3*COORD_WIDTH-1:0]       plane_box_high,
  output pbc_pkg::pbc_ctl_t              ctl_out,
  output logic signed [DW-1:0]           d_out,
  output logic signed [NEW-1:0]          ne_out,
  output logic [E2W-1:0]                 e2_out
);

  localparam int CW  = COORD_WIDTH;
  localparam int DLW = CW + 3;
  localparam int EW  = CW + 1;
  localparam int PNW = NW + DLW;
  localparam int PEW = NW + EW;
  localparam int P2W = 2 * EW;

  logic signed [CW-1:0]  mn [3];
  logic signed [CW-1:0]  mx [3];
  logic signed [CW-1:0]  org [3];
  logic signed [CW-1:0]  blo [3];
  logic signed [CW-1:0]  bhi [3];
  logic signed [NW-1:0]  nrm [3];
  logic [2:0]            apart;

  logic signed [DLW-1:0] delta2_nxt [3];
  logic signed [DLW-1:0] delta2_r [3];
  logic signed [EW-1:0]  e_nxt [3];
  logic signed [EW-1:0]  e_r [3];
  logic signed [PNW-1:0] pn_nxt [3];
  logic signed [PNW-1:0] pn_r [3];
  logic signed [PEW-1:0] pe_nxt [3];
  logic signed [PEW-1:0] pe_r [3];
  logic signed [P2W-1:0] pe2_nxt [3];
  logic signed [P2W-1:0] pe2_r [3];

  logic signed [DW-1:0]  d_nxt;
  logic signed [DW-1:0]  d_r;
  logic signed [NEW-1:0] ne_nxt;
  logic signed [NEW-1:0] ne_r;
  logic [E2W-1:0]        e2_nxt;
  logic [E2W-1:0]        e2_r;

  pbc_pkg::pbc_ctl_t ctl_a_nxt;
  pbc_pkg::pbc_ctl_t ctl_a_r;
  pbc_pkg::pbc_ctl_t ctl_b_r;
  pbc_pkg::pbc_ctl_t ctl_c_r;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign mn[i]  = box[i*CW +: CW];
    assign mx[i]  = box[(3+i)*CW +: CW];
    assign org[i] = plane_origin[(2-i)*CW +: CW];
    assign blo[i] = plane_box_low[(2-i)*CW +: CW];
    assign bhi[i] = plane_box_high[(2-i)*CW +: CW];
    assign nrm[i] = plane_normal[(2-i)*NW +: NW];

    assign apart[i]      = (mn[i] > bhi[i]) || (mx[i] < blo[i]);
    assign delta2_nxt[i] = DLW'(mx[i]) + DLW'(mn[i]) - (DLW'(org[i]) <<< 1);
    assign e_nxt[i]      = EW'(mx[i]) - EW'(mn[i]);

    assign pn_nxt[i]  = PNW'(nrm[i]) * PNW'(delta2_r[i]);
    assign pe_nxt[i]  = PEW'(nrm[i]) * PEW'(e_r[i]);
    assign pe2_nxt[i] = P2W'(e_r[i]) * P2W'(e_r[i]);
  end

  always_comb begin
    ctl_a_nxt.valid  = in_valid;
    ctl_a_nxt.reject = plane_disabled | ~flags[pbc_pkg::FLAG_BLOCKING]
                     | flags[pbc_pkg::FLAG_STATIC] | flags[pbc_pkg::FLAG_IGNORE]
                     | (|apart);
    ctl_a_nxt.neg    = 1'b0;
  end

  assign d_nxt  = DW'(pn_r[0]) + DW'(pn_r[1]) + DW'(pn_r[2]);
  assign ne_nxt = NEW'(pe_r[0]) + NEW'(pe_r[1]) + NEW'(pe_r[2]);
  assign e2_nxt = E2W'($unsigned(pe2_r[0])) + E2W'($unsigned(pe2_r[1]))
                + E2W'($unsigned(pe2_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        delta2_r[i] <= delta2_nxt[i];
        e_r[i]      <= e_nxt[i];
        pn_r[i]     <= pn_nxt[i];
        pe_r[i]     <= pe_nxt[i];
        pe2_r[i]    <= pe2_nxt[i];
      end
      d_r  <= d_nxt;
      ne_r <= ne_nxt;
      e2_r <= e2_nxt;
    end
  end

  assign ctl_out = ctl_c_r;
  assign d_out   = d_r;
  assign ne_out  = ne_r;
  assign e2_out  = e2_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pbc_test.sv
// Middle stages: side selection, distance test, nearer corner and clamped
// penetration depth (three register stages).
// Depends on pbc_pkg.
`default_nettype none

module pbc_test #(
  parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC  = pbc_pkg::COORD_FRAC_DEF,
  parameter int NORMAL_FRAC = pbc_pkg::NORMAL_FRAC_DEF,
  localparam int DW  = NORMAL_FRAC + COORD_WIDTH + 7,
  localparam int NEW = NORMAL_FRAC + COORD_WIDTH + 5,
  localparam int E2W = 2 * COORD_WIDTH + 4,
  localparam int MW  = COORD_FRAC + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pbc_pkg::pbc_ctl_t     ctl_in,
  input  logic signed [DW-1:0]  d_in,
  input  logic signed [NEW-1:0] ne_in,
  input  logic [E2W-1:0]        e2_in,
  input  logic                  two_sided,
  input  logic                  project_to_surface,
  output pbc_pkg::pbc_ctl_t     ctl_out,
  output logic [MW-1:0]         mag_out
);

  localparam int SW  = DW + 1;
  localparam int QW  = DW - NORMAL_FRAC;
  localparam int MFW = SW - NORMAL_FRAC;
  localparam logic [MW-1:0] ONE = MW'(1) << COORD_FRAC;

  logic [DW-1:0]        d_u;
  logic                 d_neg;
  logic [DW-1:0]        absd;
  logic [DW:0]          dist_sum;
  logic [QW-1:0]        distq_nxt;
  logic [QW-1:0]        distq_r;
  logic signed [SW-1:0] dmax_nxt;
  logic signed [SW-1:0] dmax_r;
  logic signed [SW-1:0] dmin_nxt;
  logic signed [SW-1:0] dmin_r;
  logic [E2W-1:0]       e2_d_r;
  logic [E2W-1:0]       e2_e_r;

  logic [2*QW-1:0]      distq2_nxt;
  logic [2*QW-1:0]      distq2_r;
  logic [SW-1:0]        abs_max;
  logic [SW-1:0]        abs_min;
  logic                 pick_max;
  logic signed [SW-1:0] dsel;
  logic [SW-1:0]        absel_nxt;
  logic [SW-1:0]        absel_r;
  logic                 side_ok_nxt;
  logic                 side_ok_r;

  logic                 far;
  logic [SW:0]          mag_sum;
  logic [MFW-1:0]       magfull;
  logic [MW-1:0]        mag_nxt;
  logic [MW-1:0]        mag_r;

  pbc_pkg::pbc_ctl_t ctl_d_nxt;
  pbc_pkg::pbc_ctl_t ctl_d_r;
  pbc_pkg::pbc_ctl_t ctl_e_r;
  pbc_pkg::pbc_ctl_t ctl_f_nxt;
  pbc_pkg::pbc_ctl_t ctl_f_r;

  // side of the center and rounded center distance
  assign d_u      = d_in;
  assign d_neg    = d_in[DW-1];
  assign absd     = d_neg ? (~d_u + DW'(1)) : d_u;
  assign dist_sum = {1'b0, absd} + ((DW+1)'(1) << NORMAL_FRAC);
  assign distq_nxt = dist_sum[DW:NORMAL_FRAC+1];
  assign dmax_nxt = SW'(d_in) + SW'(ne_in);
  assign dmin_nxt = SW'(d_in) - SW'(ne_in);

  always_comb begin
    ctl_d_nxt.valid  = ctl_in.valid;
    ctl_d_nxt.reject = ctl_in.reject | (d_neg & ~two_sided)
                     | (~project_to_surface & (d_in == '0));
    ctl_d_nxt.neg    = ~project_to_surface & d_neg;
  end

  // nearer corner; a tie goes to the minimum corner
  assign distq2_nxt = (2*QW)'(distq_r) * (2*QW)'(distq_r);
  assign abs_max    = dmax_r[SW-1] ? (~$unsigned(dmax_r) + SW'(1)) : $unsigned(dmax_r);
  assign abs_min    = dmin_r[SW-1] ? (~$unsigned(dmin_r) + SW'(1)) : $unsigned(dmin_r);
  assign pick_max   = abs_max < abs_min;
  assign dsel       = pick_max ? dmax_r : dmin_r;
  assign absel_nxt  = pick_max ? abs_max : abs_min;
  assign side_ok_nxt = ctl_d_r.neg ? (~dsel[SW-1] && (dsel != '0)) : dsel[SW-1];

  // distance test and clamped depth
  assign far     = distq2_r > (2*QW)'(e2_e_r);
  assign mag_sum = {1'b0, absel_r} + ((SW+1)'(1) << NORMAL_FRAC);
  assign magfull = mag_sum[SW:NORMAL_FRAC+1];
  assign mag_nxt = (magfull > MFW'(ONE)) ? ONE : magfull[MW-1:0];

  always_comb begin
    ctl_f_nxt        = ctl_e_r;
    ctl_f_nxt.reject = ctl_e_r.reject | far | ~side_ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
      ctl_e_r <= '0;
      ctl_f_r <= '0;
    end else if (en) begin
      ctl_d_r <= ctl_d_nxt;
      ctl_e_r <= ctl_d_r;
      ctl_f_r <= ctl_f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distq_r   <= distq_nxt;
      dmax_r    <= dmax_nxt;
      dmin_r    <= dmin_nxt;
      e2_d_r    <= e2_in;
      distq2_r  <= distq2_nxt;
      absel_r   <= absel_nxt;
      side_ok_r <= side_ok_nxt;
      e2_e_r    <= e2_d_r;
      mag_r     <= mag_nxt;
    end
  end

  assign ctl_out = ctl_f_r;
  assign mag_out = mag_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pbc_push.sv
// Back stages: normal times depth, rounding, saturation, sign, and the
// output word register.
// Depends on pbc_pkg.
`default_nettype none

module pbc_push #(
  parameter int COORD_FRAC  = pbc_pkg::COORD_FRAC_DEF,
  parameter int NORMAL_FRAC = pbc_pkg::NORMAL_FRAC_DEF,
  localparam int NW = NORMAL_FRAC + 2,
  localparam int MW = COORD_FRAC + 1,
  localparam int PW = COORD_FRAC + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  pbc_pkg::pbc_ctl_t ctl_in,
  input  logic [MW-1:0]     mag_in,
  input  logic [3*NW-1:0]   plane_normal,
  output logic              out_valid,
  output logic              contact,
  output logic [3*PW-1:0]   push
);

  localparam int PRW = NW + MW;
  localparam int RW  = PRW + 1 - NORMAL_FRAC;
  localparam logic [MW-1:0] ONE = MW'(1) << COORD_FRAC;

  logic signed [NW-1:0] nrm [3];
  logic [NW-1:0]        nabs [3];
  logic [PRW-1:0]       prod_nxt [3];
  logic [PRW-1:0]       prod_r [3];
  logic [2:0]           pneg_nxt;
  logic [2:0]           pneg_r;
  logic [PRW:0]         rsum [3];
  logic [RW-1:0]        rfull [3];
  logic [MW-1:0]        rclip [3];
  logic [3*PW-1:0]      push_nxt;
  logic [3*PW-1:0]      push_r;
  logic                 valid_r;
  logic                 contact_r;

  pbc_pkg::pbc_ctl_t ctl_g_nxt;
  pbc_pkg::pbc_ctl_t ctl_g_r;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign nrm[i]      = plane_normal[(2-i)*NW +: NW];
    assign nabs[i]     = nrm[i][NW-1] ? (~$unsigned(nrm[i]) + NW'(1)) : $unsigned(nrm[i]);
    assign prod_nxt[i] = PRW'(nabs[i]) * PRW'(mag_in);
    assign pneg_nxt[i] = nrm[i][NW-1] ^ ctl_in.neg;

    assign rsum[i]  = {1'b0, prod_r[i]} + ((PRW+1)'(1) << (NORMAL_FRAC - 1));
    assign rfull[i] = rsum[i][PRW:NORMAL_FRAC];
    assign rclip[i] = (rfull[i] > RW'(ONE)) ? ONE : rfull[i][MW-1:0];
    assign push_nxt[i*PW +: PW] = ctl_g_r.reject ? '0
                                : (pneg_r[i] ? -PW'(rclip[i]) : PW'(rclip[i]));
  end

  always_comb begin
    ctl_g_nxt        = ctl_in;
    ctl_g_nxt.reject = ctl_in.reject | (mag_in == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_g_r <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      ctl_g_r <= ctl_g_nxt;
      valid_r <= ctl_g_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      pneg_r    <= pneg_nxt;
      contact_r <= ~ctl_g_r.reject;
      push_r    <= push_nxt;
    end
  end

  assign out_valid = valid_r;
  assign contact   = contact_r;
  assign push      = push_r;

endmodule

`default_nettype wire

FILE: hw/rtl/plane_box_contact_unit.sv
// Top level of the plane/box contact unit: configuration registers, stream
// handshake and the three pipeline sections.
// Depends on pbc_pkg, pbc_geom, pbc_test and pbc_push.
`default_nettype none

// One body box is tested against the configured plane per word. The unit
// takes a new word every clock cycle while in_tready is high and returns one
// result word per input word, in order. The depth is set by the eight
// register stages around the three multiplier rows and the wide sums. A
// full output register that is not taken holds the whole pipeline, so
// in_tready drops only while out_tvalid is high and out_tready is low.
// Configuration writes take effect at once and are meant for idle periods.
module plane_box_contact_unit #(
  parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC  = pbc_pkg::COORD_FRAC_DEF,
  parameter int NORMAL_FRAC = pbc_pkg::NORMAL_FRAC_DEF,
  localparam int NW     = NORMAL_FRAC + 2,
  localparam int PW     = COORD_FRAC + 2,
  localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * PW + 7) / 8) * 8,
  localparam int CFG_DW = (COORD_WIDTH > NW) ? 3 * COORD_WIDTH : 3 * NW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [IN_DW-1:0]               in_tdata,
  // is_blocking, is_static, ignore_pair
  input  logic [pbc_pkg::FLAG_WIDTH-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // push_x, push_y, push_z
  output logic [OUT_DW-1:0]              out_tdata,
  // contact
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [pbc_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_DW-1:0]              cfg_wdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = NORMAL_FRAC + COORD_WIDTH + 7;
  localparam int NEW = NORMAL_FRAC + COORD_WIDTH + 5;
  localparam int E2W = 2 * COORD_WIDTH + 4;
  localparam int MW  = COORD_FRAC + 1;
  localparam logic [3*NW-1:0] NORMAL_RESET = (3*NW)'(1) << NORMAL_FRAC;
  localparam logic signed [PW-1:0] PUSH_MAX = PW'(1) << COORD_FRAC;

  logic            plane_disabled_r;
  logic            two_sided_r;
  logic            project_r;
  logic [3*CW-1:0] origin_r;
  logic [3*NW-1:0] normal_r;
  logic [3*CW-1:0] box_low_r;
  logic [3*CW-1:0] box_high_r;

  logic                  en;
  pbc_pkg::pbc_ctl_t     geom_ctl;
  logic signed [DW-1:0]  geom_d;
  logic signed [NEW-1:0] geom_ne;
  logic [E2W-1:0]        geom_e2;
  pbc_pkg::pbc_ctl_t     test_ctl;
  logic [MW-1:0]         test_mag;
  logic                  push_valid;
  logic                  push_contact;
  logic [3*PW-1:0]       push;
  logic                  push_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_disabled_r <= 1'b0;
      two_sided_r      <= 1'b0;
      project_r        <= 1'b0;
      origin_r         <= '0;
      normal_r         <= NORMAL_RESET;
      box_low_r        <= '0;
      box_high_r       <= '0;
    end else if (cfg_we) begin
      unique case (pbc_pkg::cfg_reg_t'(cfg_addr))
        pbc_pkg::CFG_PLANE_DISABLED: plane_disabled_r <= cfg_wdata[0];
        pbc_pkg::CFG_TWO_SIDED:      two_sided_r      <= cfg_wdata[0];
        pbc_pkg::CFG_PROJECT:        project_r        <= cfg_wdata[0];
        pbc_pkg::CFG_ORIGIN:         origin_r         <= cfg_wdata[3*CW-1:0];
        pbc_pkg::CFG_NORMAL:         normal_r         <= cfg_wdata[3*NW-1:0];
        pbc_pkg::CFG_BOX_LOW:        box_low_r        <= cfg_wdata[3*CW-1:0];
        pbc_pkg::CFG_BOX_HIGH:       box_high_r       <= cfg_wdata[3*CW-1:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the output word is held
  assign en        = ~push_valid | out_tready;
  assign in_tready = en;

  pbc_geom #(
    .COORD_WIDTH (COORD_WIDTH),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_geom (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .box            (in_tdata[6*CW-1:0]),
    .flags          (in_tuser),
    .plane_disabled (plane_disabled_r),
    .plane_origin   (origin_r),
    .plane_normal   (normal_r),
    .plane_box_low  (box_low_r),
    .plane_box_high (box_high_r),
    .ctl_out        (geom_ctl),
    .d_out          (geom_d),
    .ne_out         (geom_ne),
    .e2_out         (geom_e2)
  );

  pbc_test #(
    .COORD_WIDTH (COORD_WIDTH),
    .COORD_FRAC  (COORD_FRAC),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_test (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .ctl_in             (geom_ctl),
    .d_in               (geom_d),
    .ne_in              (geom_ne),
    .e2_in              (geom_e2),
    .two_sided          (two_sided_r),
    .project_to_surface (project_r),
    .ctl_out            (test_ctl),
    .mag_out            (test_mag)
  );

  pbc_push #(
    .COORD_FRAC  (COORD_FRAC),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_push (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .ctl_in       (test_ctl),
    .mag_in       (test_mag),
    .plane_normal (normal_r),
    .out_valid    (push_valid),
    .contact      (push_contact),
    .push         (push)
  );

  assign out_tvalid = push_valid;
  assign out_tuser  = push_contact;
  assign out_tdata  = OUT_DW'(push);

  always_comb begin
    logic signed [PW-1:0] pf;
    push_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      pf = push[i*PW +: PW];
      if ((pf > PUSH_MAX) || (pf < -PUSH_MAX)) begin
        push_ok = 1'b0;
      end
    end
  end

  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> push == '0)
    else $error("push nonzero without contact");

  a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> push_ok)
    else $error("push component beyond one unit");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held output word");

endmodule

`default_nettype wire

FILE: tb/plane_box_contact_unit_tb.sv
// Self-checking testbench for plane_box_contact_unit: directed and random body boxes
// tested against several plane settings, results checked against a built-in predictor.
// Depends on pbc_pkg and the plane_box_contact_unit RTL.
`timescale 1ns / 1ps

module plane_box_contact_unit_tb;

  localparam int CF = pbc_pkg::COORD_FRAC_DEF;
  localparam int NF = pbc_pkg::NORMAL_FRAC_DEF;
  localparam int PW = CF + 2;
  localparam int PIPE_SLACK = 16;
  localparam logic [2:0] SOLID = 3'b1 << pbc_pkg::FLAG_BLOCKING;
  localparam logic [2:0] FIXED = 3'b1 << pbc_pkg::FLAG_STATIC;
  localparam logic [2:0] SKIP = 3'b1 << pbc_pkg::FLAG_IGNORE;

  typedef struct packed {
    logic contact;
    logic [2:0][PW-1:0] push;
  } push_word_t;

  class push_ledger;
    logic disabled, two_sided, project;
    logic [59:0] origin, box_low, box_high;
    logic [47:0] normal;
    push_word_t expected_push[$];
    int errors;

    function new();
      disabled = 1'b0;
      two_sided = 1'b0;
      project = 1'b0;
      origin = '0;
      box_low = '0;
      box_high = '0;
      normal = 48'd16384;
      errors = 0;
    endfunction

    function void set_reg(pbc_pkg::cfg_reg_t idx, logic [59:0] value);
      case (idx)
        pbc_pkg::CFG_PLANE_DISABLED: disabled = value[0];
        pbc_pkg::CFG_TWO_SIDED: two_sided = value[0];
        pbc_pkg::CFG_PROJECT: project = value[0];
        pbc_pkg::CFG_ORIGIN: origin = value;
        pbc_pkg::CFG_NORMAL: normal = value[47:0];
        pbc_pkg::CFG_BOX_LOW: box_low = value;
        pbc_pkg::CFG_BOX_HIGH: box_high = value;
        default: ;
      endcase
    endfunction

    function longint magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function longint to_coord(longint x);
      return (magnitude(x) + (longint'(1) << NF)) >>> (NF + 1);
    endfunction

    function push_word_t contact_push(logic [119:0] box, logic [2:0] flags);
      longint lo[3], hi[3], nrm[3], ext[3];
      longint org, bl, bh, dcenter, spread, span2, dmax, dmin, dsel;
      longint distq, depth, scaled, r, p;
      int side;
      push_word_t res;
      res = '0;
      for (int i = 0; i < 3; i++) begin
        lo[i] = longint'($signed(box[20*i +: 20]));
        hi[i] = longint'($signed(box[60 + 20*i +: 20]));
        nrm[i] = longint'($signed(normal[16*(2-i) +: 16]));
      end
      if (disabled) return res;
      if (!flags[pbc_pkg::FLAG_BLOCKING] || flags[pbc_pkg::FLAG_STATIC]
          || flags[pbc_pkg::FLAG_IGNORE]) return res;
      for (int i = 0; i < 3; i++) begin
        bl = longint'($signed(box_low[20*(2-i) +: 20]));
        bh = longint'($signed(box_high[20*(2-i) +: 20]));
        if (lo[i] > bh || hi[i] < bl) return res;
      end
      dcenter = 0;
      spread = 0;
      span2 = 0;
      for (int i = 0; i < 3; i++) begin
        org = longint'($signed(origin[20*(2-i) +: 20]));
        ext[i] = hi[i] - lo[i];
        dcenter += nrm[i] * (hi[i] + lo[i] - 2 * org);
        spread += nrm[i] * ext[i];
        span2 += ext[i] * ext[i];
      end
      side = (dcenter > 0) ? 1 : ((dcenter < 0) ? -1 : 0);
      if (!two_sided && side < 0) return res;
      if (project) side = 1;
      if (side == 0) return res;
      distq = to_coord(dcenter);
      if (distq * distq > span2) return res;
      dmax = dcenter + spread;
      dmin = dcenter - spread;
      dsel = (magnitude(dmax) < magnitude(dmin)) ? dmax : dmin;
      if (!((side > 0 && dsel < 0) || (side < 0 && dsel > 0))) return res;
      depth = to_coord(dsel);
      if (depth > (longint'(1) << CF)) depth = longint'(1) << CF;
      if (depth == 0) return res;
      res.contact = 1'b1;
      for (int i = 0; i < 3; i++) begin
        scaled = magnitude(nrm[i]) * depth;
        r = (scaled + (longint'(1) << (NF - 1))) >>> NF;
        if (r > (longint'(1) << CF)) r = longint'(1) << CF;
        p = ((nrm[i] < 0) != (side < 0)) ? -r : r;
        res.push[i] = p[PW-1:0];
      end
      return res;
    endfunction

    function void note_box(logic [119:0] box, logic [2:0] flags);
      expected_push.push_back(contact_push(box, flags));
    endfunction

    function void check_push(logic contact, logic [31:0] data);
      string names[3];
      push_word_t want;
      names = '{"push_x", "push_y", "push_z"};
      if (expected_push.size() == 0) begin
        $error("result word with no expectation: contact %0b data %h", contact, data);
        errors++;
        return;
      end
      want = expected_push.pop_front();
      if (contact !== want.contact) begin
        $error("contact: expected %0b, got %0b", want.contact, contact);
        errors++;
      end
      for (int i = 0; i < 3; i++) begin
        if (data[PW*i +: PW] !== want.push[i]) begin
          $error("%s: expected %0d, got %0d", names[i], $signed(want.push[i]),
                 $signed(data[PW*i +: PW]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_push.size();
    endfunction

    function void close_out();
      if (expected_push.size() != 0) begin
        $error("%0d expected result words never arrived", expected_push.size());
        errors += expected_push.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [119:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we;
  logic [pbc_pkg::CFG_AW-1:0] cfg_addr;
  logic [59:0] cfg_wdata;

  int tx_idle_pct;
  int rx_idle_pct;
  push_ledger ledger = new();

  plane_box_contact_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) ledger.note_box(in_tdata, in_tuser);
      if (out_tvalid && out_tready) ledger.check_push(out_tuser, out_tdata);
    end
  end

  function automatic logic [59:0] coord3(int x, int y, int z);
    logic [31:0] a, b, c;
    a = x;
    b = y;
    c = z;
    return {a[19:0], b[19:0], c[19:0]};
  endfunction

  function automatic logic [47:0] norm3(int x, int y, int z);
    logic [31:0] a, b, c;
    a = x;
    b = y;
    c = z;
    return {a[15:0], b[15:0], c[15:0]};
  endfunction

  function automatic logic [119:0] box_word(int lx, int ly, int lz, int hx, int hy, int hz);
    return {coord3(hz, hy, hx), coord3(lz, ly, lx)};
  endfunction

  task automatic send_box(logic [119:0] word, logic [2:0] flags);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= flags;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(pbc_pkg::cfg_reg_t idx, logic [59:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.set_reg(idx, value);
  endtask

  task automatic set_plane(logic dis, logic two, logic proj, logic [59:0] org,
                           logic [47:0] nrm, logic [59:0] low, logic [59:0] high);
    drain_results();
    write_reg(pbc_pkg::CFG_PLANE_DISABLED, {59'b0, dis});
    write_reg(pbc_pkg::CFG_TWO_SIDED, {59'b0, two});
    write_reg(pbc_pkg::CFG_PROJECT, {59'b0, proj});
    write_reg(pbc_pkg::CFG_ORIGIN, org);
    write_reg(pbc_pkg::CFG_NORMAL, {12'b0, nrm});
    write_reg(pbc_pkg::CFG_BOX_LOW, low);
    write_reg(pbc_pkg::CFG_BOX_HIGH, high);
    cfg_we <= 1'b0;
  endtask

  task automatic random_plane();
    logic [59:0] org, low, high;
    logic [47:0] nrm;
    logic [31:0] r, r2;
    int o[3], lo[3], hi[3];
    for (int i = 0; i < 3; i++) begin
      o[i] = int'($urandom_range(0, 131072)) - 65536;
      lo[i] = o[i] - int'($urandom_range(0, 3000));
      hi[i] = o[i] + int'($urandom_range(0, 3000));
    end
    org = coord3(o[0], o[1], o[2]);
    low = coord3(lo[0], lo[1], lo[2]);
    high = coord3(hi[0], hi[1], hi[2]);
    if ($urandom_range(0, 9) == 0) begin
      low = coord3(-524288, -524288, -524288);
      high = coord3(524287, 524287, 524287);
    end
    r = $urandom;
    r2 = $urandom;
    case ($urandom_range(0, 5))
      0: nrm = norm3(0, 0, 16384);
      1: nrm = norm3(-16384, 0, 0);
      2: nrm = norm3(11585, -11585, 0);
      3: nrm = norm3(9459, 9459, -9459);
      4: nrm = {r[15:0], r2};
      default: nrm = norm3(int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384);
    endcase
    set_plane($urandom_range(0, 9) == 0, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
              org, nrm, low, high);
  endtask

  task automatic random_item(output logic [119:0] word, output logic [2:0] flags);
    logic [31:0] r;
    logic [19:0] lo[3], hi[3], tmp;
    int t, half, center;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 6; i++) begin
        r = $urandom;
        word[20*i +: 20] = r[19:0];
      end
      r = $urandom;
      flags = r[2:0];
    end else begin
      t = int'($urandom_range(0, 1600)) - 800;
      for (int i = 0; i < 3; i++) begin
        half = $urandom_range(0, 600);
        center = int'($signed(ledger.origin[20*(2-i) +: 20]))
               + ((t * int'($signed(ledger.normal[16*(2-i) +: 16]))) >>> 14);
        r = center - half;
        lo[i] = r[19:0];
        r = center + half;
        hi[i] = r[19:0];
        if ($urandom_range(0, 19) == 0) begin
          tmp = lo[i];
          lo[i] = hi[i];
          hi[i] = tmp;
        end
      end
      word = {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
      r = $urandom;
      flags = ($urandom_range(0, 9) == 0) ? r[2:0] : SOLID;
    end
  endtask

  initial begin
    #5_000_000;
    $display("plane_box_contact_unit regression: fail");
    $finish;
  end

  initial begin
    logic [119:0] word;
    logic [2:0] flags;
    logic [59:0] near_low, near_high;
    int guard;
    near_low = coord3(-4096, -4096, -4096);
    near_high = coord3(4096, 4096, 4096);
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= pbc_pkg::CFG_PLANE_DISABLED;
    cfg_wdata <= '0;
    tx_idle_pct = 20;
    rx_idle_pct = 70;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset plane: body centered on the plane
    send_box(box_word(-256, -256, -256, 256, 256, 256), SOLID);

    set_plane(1'b0, 1'b0, 1'b0, coord3(0, 0, 0), norm3(0, 0, 16384), near_low, near_high);
    send_box(box_word(-256, -256, -128, 256, 256, 64), SOLID);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID);
    send_box(box_word(-256, -256, -64, 256, 256, 128), 3'b0);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID | FIXED);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID | SKIP);
    send_box(box_word(5000, -256, -64, 6000, 256, 128), SOLID);
    send_box(box_word(4096, -256, -64, 4200, 256, 128), SOLID);
    send_box(box_word(-4200, -256, -64, -4096, 256, 128), SOLID);
    send_box(box_word(-16, -16, 2000, 16, 16, 2100), SOLID);
    send_box(box_word(-2000, -16, 10, 2000, 16, 20), SOLID);
    send_box(box_word(-256, -256, -1024, 256, 256, 1100), SOLID);
    send_box(box_word(-524288, -524288, -524288, 524287, 524287, 524287), SOLID);
    send_box(box_word(256, 256, 128, -256, -256, -64), SOLID);
    send_box(box_word(0, 0, 0, 0, 0, 0), SOLID);

    set_plane(1'b0, 1'b1, 1'b0, coord3(0, 0, 0), norm3(0, 0, 16384), near_low, near_high);
    send_box(box_word(-256, -256, -128, 256, 256, 64), SOLID);
    set_plane(1'b0, 1'b0, 1'b1, coord3(0, 0, 0), norm3(0, 0, 16384), near_low, near_high);
    send_box(box_word(-256, -256, -64, 256, 256, 64), SOLID);
    send_box(box_word(-256, -256, -128, 256, 256, 64), SOLID);
    set_plane(1'b0, 1'b1, 1'b1, coord3(0, 0, 0), norm3(0, 0, 16384), near_low, near_high);
    send_box(box_word(-256, -256, -128, 256, 256, 64), SOLID);

    set_plane(1'b1, 1'b1, 1'b0, coord3(0, 0, 0), norm3(0, 0, 16384), near_low, near_high);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID);
    set_plane(1'b0, 1'b1, 1'b0, coord3(0, 0, 0), norm3(0, 0, 1), near_low, near_high);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID);
    set_plane(1'b0, 1'b1, 1'b0, coord3(0, 0, 0), norm3(32767, 32767, 32767),
              near_low, near_high);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID);
    set_plane(1'b0, 1'b1, 1'b0, coord3(0, 0, 0), norm3(-32768, -32768, -32768),
              near_low, near_high);
    send_box(box_word(-256, -256, -64, 256, 256, 128), SOLID);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 3)
        set_plane(1'b0, 1'b1, 1'b1, coord3(524287, -524288, 524287), norm3(-16384, 0, 0),
                  coord3(-524288, -524288, -524288), coord3(524287, 524287, 524287));
      else
        random_plane();
      repeat (270) begin
        random_item(word, flags);
        send_box(word, flags);
      end
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (ledger.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_SLACK) @(posedge clk);
    ledger.close_out();
    if (ledger.errors == 0)
      $display("plane_box_contact_unit regression: pass");
    else
      $display("plane_box_contact_unit regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_geom.sv
hw/rtl/pbc_test.sv
hw/rtl/pbc_push.sv
hw/rtl/plane_box_contact_unit.sv
tb/plane_box_contact_unit_tb.sv
